// ===== rtl/gbts_pkg.sv =====
`timescale 1ns / 1ps

package gbts_pkg;

    localparam int CAPACITY = 4096;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int PTR_W    = ADDR_W + 1;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_ERASE  = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_APPEND = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [12:0] pos;
        logic [7:0]  ch;
        logic [12:0] count;
    } t_req;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [12:0] text_length;
        logic [1:0]  status;
    } t_res;

    typedef struct packed {
        logic load;
        logic eval;
        logic shift_rd;
        logic shift_wr;
        logic apply;
    } t_cmd;

    typedef struct packed {
        logic move_req;
        logic at_target;
    } t_stat;

endpackage

// ===== rtl/gbts_ctrl.sv =====
`timescale 1ns / 1ps

module gbts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_strobe,
    input  gbts_pkg::t_stat i_stat,
    output gbts_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_SEEK  = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_WR    = 3'd4;
    localparam logic [2:0] S_APPLY = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = i_stat.move_req ? S_SEEK : S_APPLY;
            end
            S_SEEK: begin
                n_state = i_stat.at_target ? S_APPLY : S_RD;
            end
            S_RD:    n_state = S_WR;
            S_WR:    n_state = S_SEEK;
            S_APPLY: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = (r_state == S_DONE);
    assign o_cmd.load      = (r_state == S_IDLE) && start;
    assign o_cmd.eval      = (r_state == S_EVAL);
    assign o_cmd.shift_rd  = (r_state == S_RD);
    assign o_cmd.shift_wr  = (r_state == S_WR);
    assign o_cmd.apply     = (r_state == S_APPLY);

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe && !busy)
        else $error("result strobe not followed by idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy ##1 busy)
        else $error("accepted word did not keep the block busy");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.shift_wr |-> $past(o_cmd.shift_rd))
        else $error("gap shift write without its read");

endmodule

// ===== rtl/gbts_dp.sv =====
`timescale 1ns / 1ps

module gbts_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gbts_pkg::t_req  i_req,
    input  gbts_pkg::t_cmd  i_cmd,
    output gbts_pkg::t_stat o_stat,
    output gbts_pkg::t_res  o_res
);

    localparam logic [gbts_pkg::PTR_W-1:0] CAP = gbts_pkg::PTR_W'(gbts_pkg::CAPACITY);

    logic [7:0] r_mem [gbts_pkg::CAPACITY];

    gbts_pkg::t_req r_req;
    logic [1:0]     r_status;
    logic [7:0]     r_rdata;
    logic [gbts_pkg::PTR_W-1:0] r_gap_first;
    logic [gbts_pkg::PTR_W-1:0] r_gap_past_end;

    logic [gbts_pkg::PTR_W-1:0] len;
    logic [gbts_pkg::PTR_W-1:0] target;
    logic [gbts_pkg::PTR_W-1:0] room;
    logic [gbts_pkg::PTR_W-1:0] grow;
    logic [gbts_pkg::PTR_W-1:0] read_idx;
    logic [1:0]                 n_status;
    logic                       move_left;
    logic                       full;
    logic                       ok;
    logic [gbts_pkg::ADDR_W-1:0] rd_addr;
    logic [gbts_pkg::ADDR_W-1:0] wr_addr;
    logic [7:0]                  wr_data;
    logic                        wr_en;

    assign len       = CAP - (r_gap_past_end - r_gap_first);
    assign full      = (r_gap_first >= r_gap_past_end);
    assign target    = (r_req.op == gbts_pkg::OP_APPEND) ? len : r_req.pos;
    assign move_left = (r_gap_first > target);
    assign room      = CAP - r_gap_past_end;
    assign grow      = (r_req.count < room) ? r_req.count : room;
    assign read_idx  = (r_req.pos < r_gap_first) ? r_req.pos
                     : r_gap_past_end + (r_req.pos - r_gap_first);
    assign ok        = (n_status == gbts_pkg::ST_OK);

    always_comb begin
        n_status = gbts_pkg::ST_OK;
        case (r_req.op)
            gbts_pkg::OP_INSERT: begin
                if (r_req.pos > len) begin
                    n_status = gbts_pkg::ST_RANGE;
                end else if (full) begin
                    n_status = gbts_pkg::ST_FULL;
                end
            end
            gbts_pkg::OP_ERASE: begin
                if (r_req.pos > len) begin
                    n_status = gbts_pkg::ST_RANGE;
                end
            end
            gbts_pkg::OP_READ: begin
                if (r_req.pos >= len) begin
                    n_status = gbts_pkg::ST_RANGE;
                end
            end
            gbts_pkg::OP_APPEND: begin
                if (full) begin
                    n_status = gbts_pkg::ST_FULL;
                end
            end
            default: n_status = gbts_pkg::ST_OK;
        endcase
    end

    assign o_stat.move_req  = ok && ((r_req.op == gbts_pkg::OP_INSERT)
                            || (r_req.op == gbts_pkg::OP_APPEND)
                            || ((r_req.op == gbts_pkg::OP_ERASE) && (r_req.count != '0)));
    assign o_stat.at_target = (r_gap_first == target);

    always_comb begin
        rd_addr = read_idx[gbts_pkg::ADDR_W-1:0];
        if (i_cmd.shift_rd) begin
            rd_addr = move_left ? (r_gap_first[gbts_pkg::ADDR_W-1:0] - 1'b1)
                                : r_gap_past_end[gbts_pkg::ADDR_W-1:0];
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_gap_first[gbts_pkg::ADDR_W-1:0];
        wr_data = r_req.ch;
        if (i_cmd.shift_wr) begin
            wr_en   = 1'b1;
            wr_addr = move_left ? (r_gap_past_end[gbts_pkg::ADDR_W-1:0] - 1'b1)
                                : r_gap_first[gbts_pkg::ADDR_W-1:0];
            wr_data = r_rdata;
        end else if (i_cmd.apply && (r_status == gbts_pkg::ST_OK)
                     && ((r_req.op == gbts_pkg::OP_INSERT)
                     || (r_req.op == gbts_pkg::OP_APPEND))) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.eval) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_first    <= '0;
            r_gap_past_end <= CAP;
        end else if (i_cmd.shift_wr) begin
            if (move_left) begin
                r_gap_first    <= r_gap_first - 1'b1;
                r_gap_past_end <= r_gap_past_end - 1'b1;
            end else begin
                r_gap_first    <= r_gap_first + 1'b1;
                r_gap_past_end <= r_gap_past_end + 1'b1;
            end
        end else if (i_cmd.apply && (r_status == gbts_pkg::ST_OK)) begin
            case (r_req.op)
                gbts_pkg::OP_INSERT, gbts_pkg::OP_APPEND: begin
                    r_gap_first <= r_gap_first + 1'b1;
                end
                gbts_pkg::OP_ERASE: begin
                    r_gap_past_end <= r_gap_past_end + grow;
                end
                gbts_pkg::OP_CLEAR: begin
                    r_gap_first    <= '0;
                    r_gap_past_end <= CAP;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_res.byte_out    = ((r_req.op == gbts_pkg::OP_READ)
                               && (r_status == gbts_pkg::ST_OK)) ? r_rdata : 8'd0;
    assign o_res.text_length = len;
    assign o_res.status      = r_status;

    a_gap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gap_first <= r_gap_past_end)
        else $error("gap start passed gap end");

    a_shift_keeps_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift_wr |=> $stable(len))
        else $error("gap shift changed the text length");

    a_shift_only_when_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift_rd |-> (r_status == gbts_pkg::ST_OK) && !o_stat.at_target)
        else $error("gap shift without a pending move");

endmodule

// ===== rtl/gap_buffer_text_store_unit.sv =====
`timescale 1ns / 1ps

// Gap-buffer text store of 4096 bytes. A request word is taken when start is high while busy
// is low, and exactly one result word follows on o_result, marked by o_strobe for one cycle;
// the receiver cannot stall it, so it must take every result in that cycle. Busy stays high
// from acceptance to the result. Reads, clears, zero-count erases and rejected requests pass
// through the evaluate and apply states to the done state. An insert, erase or append that is
// carried out also passes the seek state, then a read, a write and a seek again for each byte
// the gap moves (the distance from the gap to the target position), since every shifted byte
// needs a position check, a read and a dependent write of the text memory.

module gap_buffer_text_store_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  gbts_pkg::t_req i_req,
    output logic           o_strobe,
    output gbts_pkg::t_res o_result
);

    gbts_pkg::t_cmd  cmd;
    gbts_pkg::t_stat stat;

    gbts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_strobe),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    gbts_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (o_result)
    );

endmodule

// ===== sim/tb_gap_buffer_text_store_unit.sv =====
`timescale 1ns / 1ps

module tb_gap_buffer_text_store_unit;

    localparam int          CYCLE_LIMIT     = 3000000;
    localparam int          LEN_SOFT_CAP    = 200;
    localparam logic [2:0]  OP_FIRST_UNUSED = gbts_pkg::OP_CLEAR + 3'd1;
    localparam logic [2:0]  OP_LAST_UNUSED  = 3'h7;
    localparam logic [12:0] FIELD_MAX       = 13'h1FFF;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start   = 1'b0;
    logic           busy;
    gbts_pkg::t_req i_req   = '0;
    logic           o_strobe;
    gbts_pkg::t_res o_result;

    gap_buffer_text_store_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mirror of the store: text bytes around a gap from gap_lo up to gap_hi.
    logic [7:0] shadow_text [gbts_pkg::CAPACITY];
    int         gap_lo = 0;
    int         gap_hi = gbts_pkg::CAPACITY;

    gbts_pkg::t_req edit_q[$];
    gbts_pkg::t_res pending_results[$];
    int             idle_pct       = 0;
    int             mismatch_count = 0;
    int             cycle_count    = 0;
    bit             offer_next;
    gbts_pkg::t_res want;

    function automatic int text_length();
        return gbts_pkg::CAPACITY - (gap_hi - gap_lo);
    endfunction

    function automatic void shift_gap(int p);
        while (gap_lo > p && gap_hi > 0) begin
            gap_lo--;
            gap_hi--;
            shadow_text[gbts_pkg::ADDR_W'(gap_hi)] = shadow_text[gbts_pkg::ADDR_W'(gap_lo)];
        end
        while (gap_lo < p && gap_hi < gbts_pkg::CAPACITY) begin
            shadow_text[gbts_pkg::ADDR_W'(gap_lo)] = shadow_text[gbts_pkg::ADDR_W'(gap_hi)];
            gap_lo++;
            gap_hi++;
        end
    endfunction

    function automatic gbts_pkg::t_res apply_edit(gbts_pkg::t_req r);
        int             len;
        int             p;
        int             cnt;
        int             room;
        int             idx;
        gbts_pkg::t_res res;
        len = text_length();
        p   = int'(r.pos);
        cnt = int'(r.count);
        res = '0;
        res.status = gbts_pkg::ST_OK;
        case (r.op)
            gbts_pkg::OP_INSERT: begin
                if (p > len) begin
                    res.status = gbts_pkg::ST_RANGE;
                end else if (gap_lo >= gap_hi) begin
                    res.status = gbts_pkg::ST_FULL;
                end else begin
                    shift_gap(p);
                    shadow_text[gbts_pkg::ADDR_W'(gap_lo)] = r.ch;
                    gap_lo++;
                end
            end
            gbts_pkg::OP_ERASE: begin
                if (p > len) begin
                    res.status = gbts_pkg::ST_RANGE;
                end else if (cnt != 0) begin
                    shift_gap(p);
                    room = gbts_pkg::CAPACITY - gap_hi;
                    gap_hi += (cnt < room) ? cnt : room;
                end
            end
            gbts_pkg::OP_READ: begin
                if (p >= len) begin
                    res.status = gbts_pkg::ST_RANGE;
                end else begin
                    idx = (p < gap_lo) ? p : gap_hi + (p - gap_lo);
                    res.byte_out = shadow_text[gbts_pkg::ADDR_W'(idx)];
                end
            end
            gbts_pkg::OP_APPEND: begin
                if (gap_lo >= gap_hi) begin
                    res.status = gbts_pkg::ST_FULL;
                end else begin
                    shift_gap(len);
                    shadow_text[gbts_pkg::ADDR_W'(gap_lo)] = r.ch;
                    gap_lo++;
                end
            end
            gbts_pkg::OP_CLEAR: begin
                gap_lo = 0;
                gap_hi = gbts_pkg::CAPACITY;
            end
            default: begin
            end
        endcase
        res.text_length = 13'(text_length());
        return res;
    endfunction

    function automatic gbts_pkg::t_req next_random_edit();
        gbts_pkg::t_req r;
        int             len;
        int             sel;
        len     = text_length();
        sel     = $urandom_range(0, 99);
        r.op    = gbts_pkg::OP_READ;
        r.pos   = 13'($urandom_range(0, len));
        r.ch    = 8'($urandom);
        r.count = 13'($urandom_range(1, 4));
        if (len > LEN_SOFT_CAP && sel < 40) begin
            r.op    = gbts_pkg::OP_ERASE;
            r.count = 13'($urandom_range(1, 64));
        end else if (sel < 30) begin
            r.op = gbts_pkg::OP_INSERT;
        end else if (sel < 40) begin
            r.op = gbts_pkg::OP_ERASE;
            if ($urandom_range(0, 9) == 0) begin
                r.count = '0;
            end else if ($urandom_range(0, 9) == 0) begin
                r.count = 13'($urandom);
            end
        end else if (sel < 65) begin
            r.op = gbts_pkg::OP_READ;
        end else if (sel < 82) begin
            r.op  = gbts_pkg::OP_APPEND;
            r.pos = 13'($urandom);
        end else if (sel < 85) begin
            r.op = gbts_pkg::OP_CLEAR;
        end else if (sel < 88) begin
            r.op    = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
            r.pos   = 13'($urandom);
            r.count = 13'($urandom);
        end else begin
            r.op    = 3'($urandom_range(gbts_pkg::OP_INSERT, gbts_pkg::OP_CLEAR));
            r.pos   = 13'($urandom);
            r.count = 13'($urandom);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_req <= '0;
        end else begin
            if (start && !busy) begin
                pending_results.push_back(apply_edit(edit_q.pop_front()));
            end
            offer_next = start && busy;
            if (!offer_next && edit_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                offer_next = 1'b1;
            end
            start <= offer_next;
            if (offer_next) begin
                i_req <= edit_q[0];
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, o_result);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.byte_out !== want.byte_out) begin
                    $display("%0t: byte_out expected %h actual %h",
                             $time, want.byte_out, o_result.byte_out);
                    mismatch_count++;
                end
                if (o_result.text_length !== want.text_length) begin
                    $display("%0t: text_length expected %0d actual %0d",
                             $time, want.text_length, o_result.text_length);
                    mismatch_count++;
                end
                if (o_result.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_result.status);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Each word is handed over once the previous one has been accepted, so the
    // stimulus can look at the mirrored text length.
    task automatic issue(logic [2:0] op, logic [12:0] pos, logic [7:0] ch,
                         logic [12:0] count);
        gbts_pkg::t_req r;
        r.op    = op;
        r.pos   = pos;
        r.ch    = ch;
        r.count = count;
        edit_q.push_back(r);
        while (edit_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic drain();
        while (edit_q.size() != 0 || pending_results.size() != 0) @(negedge i_clk);
    endtask

    int phase_idle [4] = '{0, 51, 0, 38};

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        issue(gbts_pkg::OP_READ,   13'd0,     8'h00, 13'd0);
        issue(gbts_pkg::OP_ERASE,  13'd0,     8'h00, 13'd0);
        issue(gbts_pkg::OP_ERASE,  13'd1,     8'h00, 13'd1);
        issue(gbts_pkg::OP_INSERT, 13'd1,     8'h11, 13'd0);
        issue(gbts_pkg::OP_INSERT, 13'd0,     8'hFF, 13'd0);
        issue(gbts_pkg::OP_INSERT, 13'd0,     8'h00, 13'd0);
        issue(gbts_pkg::OP_APPEND, FIELD_MAX, 8'hA5, 13'd0);
        issue(gbts_pkg::OP_INSERT, 13'd1,     8'h5A, 13'd0);
        for (int i = 0; i <= 4; i++) begin
            issue(gbts_pkg::OP_READ, 13'(i), 8'h00, 13'd0);
        end
        issue(gbts_pkg::OP_READ,   FIELD_MAX, 8'hFF, FIELD_MAX);
        issue(gbts_pkg::OP_INSERT, FIELD_MAX, 8'hFF, FIELD_MAX);
        issue(gbts_pkg::OP_ERASE,  13'd1,     8'h00, 13'd1);
        issue(gbts_pkg::OP_ERASE,  13'd0,     8'h00, FIELD_MAX);
        for (int i = int'(OP_FIRST_UNUSED); i <= int'(OP_LAST_UNUSED); i++) begin
            issue(3'(i), FIELD_MAX, 8'hFF, FIELD_MAX);
        end
        issue(gbts_pkg::OP_APPEND, 13'd0,     8'h3C, 13'd0);
        issue(gbts_pkg::OP_CLEAR,  FIELD_MAX, 8'hFF, FIELD_MAX);
        issue(gbts_pkg::OP_READ,   13'd0,     8'h00, 13'd0);
        drain();

        foreach (phase_idle[ph]) begin
            idle_pct = phase_idle[ph];
            repeat (170) begin
                edit_q.push_back(next_random_edit());
                while (edit_q.size() != 0) @(negedge i_clk);
            end
            drain();
        end

        repeat (16) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
